// File: design/slkm_pkg.sv
// shared constants, keyword table and helper function for the serial line keyword matcher
package slkm_pkg;

  // default longest line length in bytes, newline excluded
  localparam int LineLengthDef = 32;

  // keyword table geometry
  localparam int KwCount = 8;
  localparam int KwSpan  = 22;
  localparam int ModeW   = 3;

  // byte that ends a line
  localparam logic [7:0] NewlineByte = 8'd10;

  typedef logic [KwCount-1:0]  kw_mask_t;
  typedef logic [ModeW-1:0]    mode_t;
  typedef logic [KwSpan*8-1:0] kw_text_t;

  // keyword lengths in bytes, in priority order
  localparam int KwLen [KwCount] = '{11, 10, 16, 17, 21, 22, 9, 10};

  // keyword text, right aligned: the first character sits in the highest used byte
  localparam kw_text_t KwText [KwCount] = '{
    kw_text_t'({"led_all", "_off"}),
    kw_text_t'({"led_all", "_on"}),
    kw_text_t'({"shift_left", "_ledon"}),
    kw_text_t'({"shift_right", "_ledon"}),
    kw_text_t'({"shift_left", "_keep_ledon"}),
    kw_text_t'({"shift_right", "_keep_ledon"}),
    kw_text_t'({"flower", "_on"}),
    kw_text_t'({"flower", "_off"})
  };

  // character of keyword k at line position pos, zero past its end
  function automatic logic [7:0] kw_byte(input int k, input int pos);
    int idx;
    logic [7:0] res;
    res = 8'd0;
    idx = 0;
    if (pos < KwLen[k]) begin
      idx = KwLen[k] - 1 - pos;
      res = KwText[k][idx*8 +: 8];
    end
    return res;
  endfunction

endpackage

// File: design/serial_line_keyword_matcher.sv
// serial line keyword matcher: per-byte prefix tracking and line-end keyword decode
// path: a newline waits in the input register, its result in the output register
// throughput: one byte per cycle; the only stall is a newline whose result finds
//   the output register still full and not being taken
// reset: rst_ni clears the line position, sets every keyword-alive bit, sets mode 0
//   and empties the input and output registers
module serial_line_keyword_matcher #(
  parameter int LINE_LENGTH = slkm_pkg::LineLengthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [0] matched, [3:1] mode, [7:4] zero
);

  localparam int PosW = $clog2(LINE_LENGTH);
  localparam logic [PosW-1:0] PosMax = PosW'(LINE_LENGTH - 1);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // line state
  logic [PosW-1:0]        pos_q, pos_d;
  slkm_pkg::kw_mask_t     alive_q, alive_d;
  slkm_pkg::mode_t        mode_q, mode_d;

  // result register
  logic                   out_valid_q;
  logic                   out_matched_q;
  slkm_pkg::mode_t        out_mode_q;

  logic is_nl;
  logic adv;
  logic hit;

  // stage advances unless a newline result would overwrite a waiting result
  assign is_nl = (in_byte_q == slkm_pkg::NewlineByte);
  assign adv   = in_valid_q && (!is_nl || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;

  // per-byte prefix tracking and line-end priority decode
  always_comb begin
    pos_d   = pos_q;
    alive_d = alive_q;
    mode_d  = mode_q;
    hit     = 1'b0;
    if (is_nl) begin
      for (int k = slkm_pkg::KwCount - 1; k >= 0; k--) begin
        if (alive_q[k] && (int'(pos_q) >= slkm_pkg::KwLen[k])) begin
          hit    = 1'b1;
          mode_d = slkm_pkg::ModeW'(k);
        end
      end
      pos_d   = '0;
      alive_d = '1;
    end else if (pos_q < PosMax) begin
      for (int k = 0; k < slkm_pkg::KwCount; k++) begin
        if ((int'(pos_q) < slkm_pkg::KwLen[k]) &&
            (slkm_pkg::kw_byte(k, int'(pos_q)) != in_byte_q)) begin
          alive_d[k] = 1'b0;
        end
      end
      pos_d = pos_q + 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      alive_q     <= '1;
      mode_q      <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (adv) begin
        pos_q   <= pos_d;
        alive_q <= alive_d;
        mode_q  <= mode_d;
      end
      if (adv && is_nl) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (adv && is_nl) begin
      out_matched_q <= hit;
      out_mode_q    <= mode_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_mode_q, out_matched_q};

  // a finished line leaves fresh line state behind
  a_line_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && is_nl |=> (pos_q == '0) && (alive_q == '1))
    else $error("line state not restarted after newline");

  // position counter never passes its saturation point
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosMax)
    else $error("line position beyond saturation");

  // the stage only holds a newline blocked by a full, stalled result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |-> is_nl && out_valid_q && !m_axis_tready_i)
    else $error("input stage stalled without cause");

  // a shown result carries the current stored mode
  a_mode_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_mode_q == mode_q))
    else $error("result mode differs from stored mode");

endmodule

// File: dv/tb_top.sv
// testbench for the serial line keyword matcher: directed, random, output stall, full rate
module tb_top;

  localparam int LineLen   = slkm_pkg::LineLengthDef;
  localparam int IdleLimit = 2000;
  localparam int TotalBytes = 1650;

  typedef struct packed {
    logic            matched;
    slkm_pkg::mode_t mode;
  } line_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic [7:0] s_axis_tdata = 8'd0;
  logic       s_axis_tready;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;

  // keyword text in priority order
  string cmd_words [slkm_pkg::KwCount] = '{
    {string'("led_all"), "_off"}, {string'("led_all"), "_on"},
    {string'("shift_left"), "_ledon"}, {string'("shift_right"), "_ledon"},
    {string'("shift_left"), "_keep_ledon"}, {string'("shift_right"), "_keep_ledon"},
    {string'("flower"), "_on"}, {string'("flower"), "_off"}
  };

  // line tracking state of the predictor
  int                 line_pos;
  slkm_pkg::kw_mask_t words_alive;
  slkm_pkg::mode_t    cur_mode;

  line_result_t pending_results[$];
  bit           idle_on = 1'b1;
  int           hold_left = 0;
  int           error_count = 0;
  int           bytes_sent = 0;
  int           lines_done = 0;
  int           hits = 0;
  logic [slkm_pkg::KwCount-1:0] modes_hit = '0;

  serial_line_keyword_matcher u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // advance the line state by one accepted byte, queue the line result on newline
  function automatic void track_byte(input logic [7:0] b);
    bit hit;
    hit = 1'b0;
    if (b == slkm_pkg::NewlineByte) begin
      for (int k = 0; k < slkm_pkg::KwCount; k++) begin
        if (!hit && words_alive[k] && line_pos >= cmd_words[k].len()) begin
          cur_mode = slkm_pkg::mode_t'(k);
          hit = 1'b1;
        end
      end
      pending_results.push_back('{matched: hit, mode: cur_mode});
      lines_done++;
      if (hit) begin
        hits++;
        modes_hit[cur_mode] = 1'b1;
      end
      line_pos = 0;
      words_alive = '1;
    end else if (line_pos < LineLen - 1) begin
      for (int k = 0; k < slkm_pkg::KwCount; k++) begin
        if (line_pos < cmd_words[k].len() && cmd_words[k][line_pos] != b)
          words_alive[k] = 1'b0;
      end
      line_pos++;
    end
  endfunction

  function automatic logic [7:0] any_but_newline();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == slkm_pkg::NewlineByte);
    return b;
  endfunction

  // offer one byte, wait for the handshake, then update the prediction
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    track_byte(b);
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(slkm_pkg::NewlineByte);
  endtask

  // keyword line, maybe cut short, maybe with one bad byte, maybe with trailing text
  task automatic send_keyword_line();
    int k;
    int len;
    int bad_pos;
    k = $urandom_range(0, slkm_pkg::KwCount - 1);
    len = cmd_words[k].len();
    if ($urandom_range(0, 4) == 0) len = $urandom_range(0, len - 1);
    bad_pos = ($urandom_range(0, 6) == 0) ? $urandom_range(0, len) : -1;
    for (int i = 0; i < len; i++)
      send_byte(i == bad_pos ? any_but_newline() : 8'(cmd_words[k][i]));
    repeat ($urandom_range(0, 4))
      send_byte($urandom_range(0, 2) == 0 ? 8'd13 : any_but_newline());
    send_byte(slkm_pkg::NewlineByte);
  endtask

  // random bytes of any value, long enough at times to saturate the position
  task automatic send_noise_line();
    repeat ($urandom_range(0, 45)) send_byte(8'($urandom_range(0, 255)));
    send_byte(slkm_pkg::NewlineByte);
  endtask

  task automatic test_directed();
    for (int k = 0; k < slkm_pkg::KwCount; k++) send_line(cmd_words[k]);
    send_line("");
    send_line("led_all_o");
    send_line({string'("LED_ALL"), "_OFF"});
    send_line({cmd_words[6], "\r"});
    send_line({cmd_words[5], "xxxxxxxxxxxxxxxxxxxxxxxxxxxx"});
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(slkm_pkg::NewlineByte);
    // keyword followed by odd bytes before the newline
    for (int i = 0; i < cmd_words[0].len(); i++) send_byte(cmd_words[0][i]);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(slkm_pkg::NewlineByte);
  endtask

  task automatic test_random_lines();
    while (bytes_sent < 1250) begin
      if ($urandom_range(0, 9) < 7) send_keyword_line();
      else send_noise_line();
    end
  endtask

  // output held off for a long stretch while short lines keep coming
  task automatic test_output_stall();
    hold_left = 300;
    repeat (30) begin
      if ($urandom_range(0, 1) == 0) send_byte(slkm_pkg::NewlineByte);
      else send_line(cmd_words[$urandom_range(6, 7)]);
    end
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    while (bytes_sent < TotalBytes) begin
      if ($urandom_range(0, 9) < 8) send_keyword_line();
      else send_noise_line();
    end
  endtask

  // result checker and output flow control
  initial begin
    line_result_t exp_res;
    int burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: tdata %h", m_axis_tdata);
          error_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (m_axis_tdata[0] !== exp_res.matched) begin
            $error("matched: expected %0d, actual %0d", exp_res.matched, m_axis_tdata[0]);
            error_count++;
          end
          if (m_axis_tdata[3:1] !== exp_res.mode) begin
            $error("mode: expected %0d, actual %0d", exp_res.mode, m_axis_tdata[3:1]);
            error_count++;
          end
          if (m_axis_tdata[7:4] !== 4'd0) begin
            $error("padding: expected 0, actual %0d", m_axis_tdata[7:4]);
            error_count++;
          end
        end
      end
      if (!rst_ni) begin
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= IdleLimit) begin
        $display("timeout: no handshake for %0d cycles", IdleLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    line_pos = 0;
    words_alive = '1;
    cur_mode = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_lines();
    test_output_stall();
    test_full_rate();
    s_axis_tvalid <= 1'b0;

    // drain outstanding results, then allow the pipeline to settle
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end

    $display("sent %0d bytes forming %0d lines, %0d of them matched a keyword",
             bytes_sent, lines_done, hits);
    $display("modes reached: %b, output held off once for 300 cycles", modes_hit);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: serial_line_keyword_matcher.f
design/slkm_pkg.sv
design/serial_line_keyword_matcher.sv
dv/tb_top.sv
